// ----- hw/rtl/axis_path_point_collector_macros.svh -----
// Assertion helpers shared by the RTL. All checks are clocked on clk_i and
// are off while rst_ni is low.
`ifndef AXIS_PATH_POINT_COLLECTOR_MACROS_SVH
`define AXIS_PATH_POINT_COLLECTOR_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define APC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/apc_pkg.sv -----
package apc_pkg;

  localparam int unsigned NUM_POINTS_DEF = 256;

  localparam int unsigned COORD_W = 48;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned CNT_W   = 9;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] POS_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_PLACE = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;

  // move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // one table entry as stored in RAM
  typedef struct packed {
    logic                       valid;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } point_t;

  localparam int unsigned POINT_W = $bits(point_t);

endpackage

// ----- hw/rtl/apc_ram.sv -----
module apc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/axis_path_point_collector.sv -----
// Sequence: a load runs RANGE, SCAN and FIN from accept to done_o, a move runs SETUP
//   before those, and a place or unused mode goes straight to FIN.
// Throughput: one item at a time, set by the table scan at one RAM read per cycle.
// done_o pulses for one cycle and the receiver cannot stall; start_i is taken
//   again at the edge that ends the pulse.
// Reset (async, active low) clears position, counts and fill pointer; RAM is not cleared.
module axis_path_point_collector #(
  parameter int unsigned NUM_POINTS = apc_pkg::NUM_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [apc_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [apc_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [1:0]                          direction_i,
  input  logic [apc_pkg::DIST_W-1:0]          distance_i,
  output logic                                done_o,
  output logic signed [apc_pkg::COORD_W-1:0]  pos_x_o,
  output logic signed [apc_pkg::COORD_W-1:0]  pos_y_o,
  output logic [apc_pkg::CNT_W-1:0]           visited_total_o,
  output logic                                table_full_o
);

  `include "axis_path_point_collector_macros.svh"

  localparam int unsigned AW    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned CW    = $clog2(NUM_POINTS + 1);
  localparam int unsigned CRD_W = apc_pkg::COORD_W;
  localparam int unsigned SUM_W = CRD_W + 2;
  localparam logic [CW-1:0] FILL_MAX = CW'(NUM_POINTS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for start_i
  localparam logic [2:0] ST_SETUP = 3'd1;  // move: saturated end point
  localparam logic [2:0] ST_RANGE = 3'd2;  // match key and [lo, hi] window
  localparam logic [2:0] ST_SCAN  = 3'd3;  // walk the table, one entry per cycle
  localparam logic [2:0] ST_FIN   = 3'd4;  // commit position / append point

  logic [2:0] state_q, state_d;

  // captured item
  logic [1:0]              mode_q;
  logic signed [CRD_W-1:0] kx_q, ky_q;
  logic [1:0]              dir_q;
  logic [apc_pkg::DIST_W-1:0] dist_q;

  // architectural state
  logic signed [CRD_W-1:0]   cur_x_q, cur_y_q;
  logic [CW-1:0]             fill_q;
  logic [apc_pkg::CNT_W-1:0] visit_q;

  // scan control
  logic signed [CRD_W-1:0] end_q;     // saturated move end on the moving axis
  logic signed [CRD_W-1:0] key_q;     // coordinate that must match exactly
  logic signed [CRD_W-1:0] lo_q, hi_q;
  logic                    vert_q;    // key is x, window is on y
  logic [CW-1:0]           idx_q;
  logic                    rd_vld_q;
  logic [AW-1:0]           rd_addr_q;
  logic                    dup_q;

  // result
  logic done_q;
  logic full_q;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic accept;
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // move end point: one add on the moving axis, then clamp to 48-bit signed
  // ---------------------------------------------------------------------------
  logic                    mv_vert;
  logic                    mv_inc;
  logic signed [CRD_W-1:0] ax_cur;
  logic signed [SUM_W-1:0] ax_ext, dist_ext, ax_sum;
  logic signed [CRD_W-1:0] ax_end;

  assign mv_vert  = (dir_q == apc_pkg::DIR_UP) || (dir_q == apc_pkg::DIR_DOWN);
  assign mv_inc   = (dir_q == apc_pkg::DIR_UP) || (dir_q == apc_pkg::DIR_RIGHT);
  assign ax_cur   = mv_vert ? cur_y_q : cur_x_q;
  assign ax_ext   = {{2{ax_cur[CRD_W-1]}}, ax_cur};
  assign dist_ext = {{(SUM_W-apc_pkg::DIST_W){1'b0}}, dist_q};
  assign ax_sum   = mv_inc ? (ax_ext + dist_ext) : (ax_ext - dist_ext);

  always_comb begin
    // top three bits disagree means the sum left the 48-bit range
    if (ax_sum[SUM_W-1:CRD_W-1] == 3'b000 || ax_sum[SUM_W-1:CRD_W-1] == 3'b111) begin
      ax_end = ax_sum[CRD_W-1:0];
    end else if (ax_sum[SUM_W-1]) begin
      ax_end = apc_pkg::POS_MIN;
    end else begin
      ax_end = apc_pkg::POS_MAX;
    end
  end

  // ---------------------------------------------------------------------------
  // point RAM: {valid, x, y}; only entries below the fill pointer are read
  // ---------------------------------------------------------------------------
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr;
  apc_pkg::point_t          ram_wdata, rd_pt;
  logic [apc_pkg::POINT_W-1:0] ram_rdata;

  apc_ram #(
    .WIDTH (apc_pkg::POINT_W),
    .DEPTH (NUM_POINTS),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_pt = apc_pkg::point_t'(ram_rdata);

  // read issue: each entry is read once, write-back lands in the cycle after
  // the read on an entry already passed, so reads and writes never collide
  assign ram_re = (state_q == ST_SCAN) && (idx_q < fill_q);

  // match against the scanned entry; a load uses key = x, window = [y, y]
  logic signed [CRD_W-1:0] eq_val, rng_val;
  logic                    hit;

  assign eq_val  = vert_q ? rd_pt.x : rd_pt.y;
  assign rng_val = vert_q ? rd_pt.y : rd_pt.x;
  assign hit     = (state_q == ST_SCAN) && rd_vld_q && rd_pt.valid &&
                   (eq_val == key_q) && (rng_val >= lo_q) && (rng_val <= hi_q);

  logic do_collect, do_append, can_append;
  assign can_append = (fill_q < FILL_MAX);
  assign do_collect = hit && (mode_q == apc_pkg::MODE_MOVE);
  assign do_append  = (state_q == ST_FIN) && (mode_q == apc_pkg::MODE_LOAD) &&
                      !dup_q && can_append;

  always_comb begin
    ram_we    = do_collect || do_append;
    ram_waddr = rd_addr_q;
    ram_wdata = rd_pt;
    if (do_append) begin
      ram_waddr       = fill_q[AW-1:0];
      ram_wdata.valid = 1'b1;
      ram_wdata.x     = kx_q;
      ram_wdata.y     = ky_q;
    end else begin
      ram_wdata.valid = 1'b0;  // collected point drops out of the set
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            apc_pkg::MODE_LOAD: state_d = ST_RANGE;
            apc_pkg::MODE_MOVE: state_d = ST_SETUP;
            default:            state_d = ST_FIN;
          endcase
        end
      end
      ST_SETUP: state_d = ST_RANGE;
      ST_RANGE: state_d = ST_SCAN;
      ST_SCAN: begin
        if (!ram_re && !rd_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      fill_q   <= '0;
      visit_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      dup_q    <= 1'b0;
      done_q   <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      done_q   <= (state_q == ST_FIN);

      if (accept) begin
        idx_q <= '0;
        dup_q <= 1'b0;
      end
      if (ram_re) begin
        idx_q <= idx_q + 1'b1;
      end

      if (hit && (mode_q == apc_pkg::MODE_LOAD)) begin
        dup_q <= 1'b1;
      end
      if (do_collect && (visit_q != apc_pkg::CNT_MAX)) begin
        visit_q <= visit_q + 1'b1;
      end
      if (do_append) begin
        fill_q <= fill_q + 1'b1;
      end

      if (state_q == ST_FIN) begin
        full_q <= (mode_q == apc_pkg::MODE_LOAD) && !dup_q && !can_append;
        case (mode_q)
          apc_pkg::MODE_PLACE: begin
            cur_x_q <= kx_q;
            cur_y_q <= ky_q;
          end
          apc_pkg::MODE_MOVE: begin
            if (vert_q) begin
              cur_y_q <= end_q;
            end else begin
              cur_x_q <= end_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      kx_q   <= coord_x_i;
      ky_q   <= coord_y_i;
      dir_q  <= direction_i;
      dist_q <= distance_i;
    end
    if (state_q == ST_SETUP) begin
      end_q <= ax_end;
    end
    if (state_q == ST_RANGE) begin
      if (mode_q == apc_pkg::MODE_LOAD) begin
        vert_q <= 1'b1;
        key_q  <= kx_q;
        lo_q   <= ky_q;
        hi_q   <= ky_q;
      end else begin
        vert_q <= mv_vert;
        key_q  <= mv_vert ? cur_x_q : cur_y_q;
        lo_q   <= (ax_cur < end_q) ? ax_cur : end_q;
        hi_q   <= (ax_cur < end_q) ? end_q : ax_cur;
      end
    end
    if (ram_re) begin
      rd_addr_q <= idx_q[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // outputs: state registers hold the post-item values during the done pulse
  // ---------------------------------------------------------------------------
  assign done_o          = done_q;
  assign pos_x_o         = cur_x_q;
  assign pos_y_o         = cur_y_q;
  assign visited_total_o = visit_q;
  assign table_full_o    = full_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `APC_ASSERT(a_done_single, done_o |=> !done_o, "done pulse longer than one cycle")
  `APC_ASSERT(a_done_idle, done_o |-> !busy_o, "result shown while still busy")
  `APC_ASSERT(a_accept_busy, accept |=> busy_o, "accepted item did not start work")
  `APC_ASSERT_NEVER(a_we_idle, ram_we && (state_q == ST_IDLE), "RAM write while idle")
  `APC_ASSERT_NEVER(a_fill_bound, fill_q > FILL_MAX, "fill pointer past table depth")
  `APC_ASSERT_NEVER(a_read_past_fill, ram_re && (idx_q >= fill_q), "read beyond fill pointer")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NPTS         = apc_pkg::NUM_POINTS_DEF;
  // Longest quiet stretch: a full table scan plus a long sender gap, several times over
  localparam int unsigned QUIET_LIMIT  = 8 * (NPTS + 4) + 400;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned MAX_LOGGED   = 40;

  // mode 3 is not decoded by the block; it just echoes the current state
  localparam logic [1:0] MODE_IDLE = 2'd3;

  typedef struct {
    logic signed [apc_pkg::COORD_W-1:0] px;
    logic signed [apc_pkg::COORD_W-1:0] py;
    logic [apc_pkg::CNT_W-1:0]          total;
    logic                               full;
  } report_t;

  // Tracks the point set, the position and the collected count, and holds the
  // report owed for every item the block has taken.
  class collector_tracker;
    logic signed [apc_pkg::COORD_W-1:0] mark_x [NPTS];
    logic signed [apc_pkg::COORD_W-1:0] mark_y [NPTS];
    bit                                 mark_live [NPTS];
    int unsigned                        used;
    logic signed [apc_pkg::COORD_W-1:0] at_x;
    logic signed [apc_pkg::COORD_W-1:0] at_y;
    int unsigned                        collected;
    report_t                            owed [$];
    int unsigned                        errors;

    function new();
      foreach (mark_live[i]) mark_live[i] = 1'b0;
      used      = 0;
      at_x      = '0;
      at_y      = '0;
      collected = 0;
      errors    = 0;
    endfunction

    static function longint clamp_pos(longint v);
      if (v > longint'(apc_pkg::POS_MAX)) return longint'(apc_pkg::POS_MAX);
      if (v < longint'(apc_pkg::POS_MIN)) return longint'(apc_pkg::POS_MIN);
      return v;
    endfunction

    function void apply_item(input logic [1:0] mode,
                             input logic signed [apc_pkg::COORD_W-1:0] cx,
                             input logic signed [apc_pkg::COORD_W-1:0] cy,
                             input logic [1:0] dir,
                             input logic [apc_pkg::DIST_W-1:0] step_len);
      bit      dropped;
      bit      dup;
      bit      vertical;
      bit      hit;
      longint  ox, oy, nx, ny, lo, hi, span;
      report_t r;
      dropped = 1'b0;
      case (mode)
        apc_pkg::MODE_LOAD: begin
          dup = 1'b0;
          for (int i = 0; i < used; i++)
            if (mark_live[i] && mark_x[i] == cx && mark_y[i] == cy) dup = 1'b1;
          if (!dup) begin
            // freed slots are never reused: append only
            if (used >= NPTS) begin
              dropped = 1'b1;
            end else begin
              mark_x[used]    = cx;
              mark_y[used]    = cy;
              mark_live[used] = 1'b1;
              used++;
            end
          end
        end
        apc_pkg::MODE_PLACE: begin
          at_x = cx;
          at_y = cy;
        end
        apc_pkg::MODE_MOVE: begin
          ox   = at_x;
          oy   = at_y;
          nx   = ox;
          ny   = oy;
          span = longint'(step_len);
          case (dir)
            apc_pkg::DIR_UP:   ny = clamp_pos(oy + span);
            apc_pkg::DIR_DOWN: ny = clamp_pos(oy - span);
            apc_pkg::DIR_LEFT: nx = clamp_pos(ox - span);
            default:           nx = clamp_pos(ox + span);
          endcase
          vertical = (dir == apc_pkg::DIR_UP) || (dir == apc_pkg::DIR_DOWN);
          if (vertical) begin
            lo = (oy < ny) ? oy : ny;
            hi = (oy < ny) ? ny : oy;
          end else begin
            lo = (ox < nx) ? ox : nx;
            hi = (ox < nx) ? nx : ox;
          end
          // closed segment, saturated end included
          for (int i = 0; i < used; i++) begin
            if (vertical)
              hit = longint'(mark_x[i]) == ox &&
                    longint'(mark_y[i]) >= lo && longint'(mark_y[i]) <= hi;
            else
              hit = longint'(mark_y[i]) == oy &&
                    longint'(mark_x[i]) >= lo && longint'(mark_x[i]) <= hi;
            if (mark_live[i] && hit) begin
              mark_live[i] = 1'b0;
              if (collected < apc_pkg::CNT_MAX) collected++;
            end
          end
          at_x = nx[apc_pkg::COORD_W-1:0];
          at_y = ny[apc_pkg::COORD_W-1:0];
        end
        default: ;
      endcase
      r.px    = at_x;
      r.py    = at_y;
      r.total = collected[apc_pkg::CNT_W-1:0];
      r.full  = dropped;
      owed.push_back(r);
    endfunction

    task log_mismatch(input string what);
      if (errors < MAX_LOGGED) $display("%0t ns mismatch: %s", $time, what);
      errors++;
    endtask

    task match_report(input logic signed [apc_pkg::COORD_W-1:0] px,
                      input logic signed [apc_pkg::COORD_W-1:0] py,
                      input logic [apc_pkg::CNT_W-1:0] total,
                      input logic full);
      report_t want;
      if (owed.size() == 0) begin
        log_mismatch("result with no item outstanding");
      end else begin
        want = owed.pop_front();
        if (px !== want.px)
          log_mismatch($sformatf("pos_x got %0d want %0d", px, want.px));
        if (py !== want.py)
          log_mismatch($sformatf("pos_y got %0d want %0d", py, want.py));
        if (total !== want.total)
          log_mismatch($sformatf("visited_total got %0d want %0d", total, want.total));
        if (full !== want.full)
          log_mismatch($sformatf("table_full got %0b want %0b", full, want.full));
      end
    endtask

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic [1:0]                         mode_i;
  logic signed [apc_pkg::COORD_W-1:0] coord_x_i;
  logic signed [apc_pkg::COORD_W-1:0] coord_y_i;
  logic [1:0]                         direction_i;
  logic [apc_pkg::DIST_W-1:0]         distance_i;
  logic                               done_o;
  logic signed [apc_pkg::COORD_W-1:0] pos_x_o;
  logic signed [apc_pkg::COORD_W-1:0] pos_y_o;
  logic [apc_pkg::CNT_W-1:0]          visited_total_o;
  logic                               table_full_o;

  collector_tracker board = new();

  axis_path_point_collector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .direction_i    (direction_i),
    .distance_i     (distance_i),
    .done_o         (done_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .visited_total_o(visited_total_o),
    .table_full_o   (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Presents one item and holds it until taken (start high, busy low at an
  // edge). Called at a clock edge; returns at the edge that took the item,
  // with start_i still high so a back-to-back item needs no extra NBA.
  task automatic drive_item(input logic [1:0] mode,
                            input logic signed [apc_pkg::COORD_W-1:0] cx,
                            input logic signed [apc_pkg::COORD_W-1:0] cy,
                            input logic [1:0] dir,
                            input logic [apc_pkg::DIST_W-1:0] step_len,
                            input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    mode_i      <= mode;
    coord_x_i   <= cx;
    coord_y_i   <= cy;
    direction_i <= dir;
    distance_i  <= step_len;
    do @(posedge clk_i); while (busy_o);
    board.apply_item(mode, cx, cy, dir, step_len);
  endtask

  // Random item around a grid origin (bx, by). Most items are loads, places
  // and short moves on a 17x17 grid, so moves run over stored points often and
  // the table fills up during the run. The rest is full-range noise,
  // including the undecoded mode and long, saturating moves.
  task automatic random_item(input int unsigned idle_pct, input longint bx, input longint by);
    int unsigned                  pick;
    longint                       gx, gy;
    logic [apc_pkg::DIST_W-1:0]   step_len;
    logic [2*apc_pkg::DIST_W-1:0] rx, ry;
    pick     = $urandom_range(99);
    gx       = bx + longint'($urandom_range(16)) - 8;
    gy       = by + longint'($urandom_range(16)) - 8;
    step_len = ($urandom_range(15) == 0) ? $urandom : $urandom_range(12);
    rx       = {$urandom, $urandom};
    ry       = {$urandom, $urandom};
    if (pick < 40)
      drive_item(apc_pkg::MODE_LOAD, gx[apc_pkg::COORD_W-1:0], gy[apc_pkg::COORD_W-1:0],
                 2'($urandom_range(3)), $urandom, idle_pct);
    else if (pick < 52)
      drive_item(apc_pkg::MODE_PLACE, gx[apc_pkg::COORD_W-1:0], gy[apc_pkg::COORD_W-1:0],
                 2'($urandom_range(3)), $urandom, idle_pct);
    else if (pick < 88)
      drive_item(apc_pkg::MODE_MOVE, rx[apc_pkg::COORD_W-1:0], ry[apc_pkg::COORD_W-1:0],
                 2'($urandom_range(3)), step_len, idle_pct);
    else
      drive_item(2'($urandom_range(3)), rx[apc_pkg::COORD_W-1:0], ry[apc_pkg::COORD_W-1:0],
                 2'($urandom_range(3)), $urandom, idle_pct);
  endtask

  // Results cannot be stalled; just sample them at the edge ending the strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      board.match_report(pos_x_o, pos_y_o, visited_total_o, table_full_o);
  end

  // Watchdog: any item taken or result seen restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned idle;
    longint      bx, by;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    mode_i      <= apc_pkg::MODE_LOAD;
    coord_x_i   <= '0;
    coord_y_i   <= '0;
    direction_i <= apc_pkg::DIR_UP;
    distance_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed items ---
    drive_item(apc_pkg::MODE_MOVE,  0,  0, apc_pkg::DIR_UP, 0, 0);     // zero move, empty set
    drive_item(apc_pkg::MODE_LOAD,  0,  0, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_LOAD,  0,  0, apc_pkg::DIR_DOWN, 0, 0);   // duplicate of live point
    drive_item(apc_pkg::MODE_LOAD,  0,  3, apc_pkg::DIR_LEFT, 0, 0);
    drive_item(apc_pkg::MODE_LOAD,  0, -2, apc_pkg::DIR_RIGHT, 0, 0);
    drive_item(apc_pkg::MODE_LOAD,  5,  0, apc_pkg::DIR_UP, 0, 0);
    drive_item(MODE_IDLE, apc_pkg::COORD_W'({$urandom, $urandom}),
               apc_pkg::COORD_W'({$urandom, $urandom}), apc_pkg::DIR_RIGHT, $urandom, 0);
    drive_item(apc_pkg::MODE_PLACE, 0,  0, apc_pkg::DIR_UP, 0, 0);     // point under us, kept
    drive_item(apc_pkg::MODE_MOVE,  0,  0, apc_pkg::DIR_UP, 3, 0);     // both segment ends
    drive_item(apc_pkg::MODE_MOVE,  0,  0, apc_pkg::DIR_DOWN, 5, 0);
    drive_item(apc_pkg::MODE_LOAD,  0,  0, apc_pkg::DIR_UP, 0, 0);     // collected point returns
    drive_item(apc_pkg::MODE_PLACE, -1, 0, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_MOVE,  0,  0, apc_pkg::DIR_RIGHT, 6, 0);
    drive_item(apc_pkg::MODE_LOAD,  5,  0, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_MOVE,  0,  0, apc_pkg::DIR_LEFT, 0, 0);   // zero move collects
    drive_item(apc_pkg::MODE_LOAD,  apc_pkg::POS_MAX, apc_pkg::POS_MIN, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_LOAD,  apc_pkg::POS_MIN, apc_pkg::POS_MAX, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_PLACE, apc_pkg::POS_MAX - 2, apc_pkg::POS_MIN,
               apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_MOVE,  0, 0, apc_pkg::DIR_RIGHT, 32'hFFFF_FFFF, 0); // hits +max
    drive_item(apc_pkg::MODE_PLACE, apc_pkg::POS_MIN, apc_pkg::POS_MAX, apc_pkg::DIR_UP, 0, 0);
    drive_item(apc_pkg::MODE_MOVE,  0, 0, apc_pkg::DIR_LEFT, 32'hFFFF_FFFF, 0);  // already at POS_MIN
    drive_item(apc_pkg::MODE_MOVE,  0, 0, apc_pkg::DIR_UP, 32'hFFFF_FFFF, 0);
    drive_item(apc_pkg::MODE_MOVE,  0, 0, apc_pkg::DIR_DOWN, 1, 0);
    drive_item(apc_pkg::MODE_PLACE, 0, 0, apc_pkg::DIR_UP, 0, 0);

    // --- random items: three sender idle rates, three grid origins ---
    for (int ph = 0; ph < 3; ph++) begin
      idle = (ph == 0) ? 9 : (ph == 1) ? 47 : 0;
      case (ph)
        0: begin
          bx = 0;
          by = 0;
        end
        1: begin
          bx = longint'(apc_pkg::POS_MAX) - 8;
          by = longint'(apc_pkg::POS_MIN) + 8;
        end
        default: begin
          bx = longint'(apc_pkg::POS_MIN) + 8;
          by = longint'(apc_pkg::POS_MAX) - 8;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) random_item(idle, bx, by);
      // hold off until the block has answered everything
      start_i <= 1'b0;
      do @(posedge clk_i); while (board.outstanding() != 0);
    end

    repeat (NPTS + 8) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
